@@ sv/rac_pkg.sv @@
// Shared types and constants of the rotating actuator crossfade block.
package rac_pkg;

	localparam int ELAPSED_W = 16;
	localparam int CHANNEL_W = 4;
	localparam int LEVEL_W = 8;
	localparam int FREQ_W = 16;
	localparam int PHASE_W = 32;
	localparam int ACC_W = 40;
	localparam int MPLIER_W = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int LOG2_OUTPUTS_DEF = 2;

	localparam logic [MPLIER_W-1:0] PHASE_PER_MS_HZ = 16'd16777;
	localparam logic [LEVEL_W-1:0] INTENSITY_RST = 8'd0;
	localparam logic [FREQ_W-1:0] FREQ_RST = 16'd256;

	// Register index, taken from paddr[2].
	localparam logic REG_INTENSITY = 1'b0;
	localparam logic REG_FREQ = 1'b1;

	typedef struct packed {
		logic start;
		logic [ACC_W-1:0] mcand;
		logic [MPLIER_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [ACC_W-1:0] prod;
	} mul_rsp_t;

endpackage

@@ sv/rac_if.sv @@
// Request channel interfaces of the rotating actuator crossfade block.
interface rac_tick_if;
	logic valid;
	logic ready;
	logic [rac_pkg::ELAPSED_W-1:0] elapsed_ms;

	modport source(output valid, output elapsed_ms, input ready);
	modport sink(input valid, input elapsed_ms, output ready);
endinterface

interface rac_result_if;
	logic valid;
	logic ready;
	logic [rac_pkg::CHANNEL_W-1:0] channel;
	logic [rac_pkg::LEVEL_W-1:0] level;
	logic changed;
	logic last;

	modport source(output valid, output channel, output level, output changed, output last,
		input ready);
	modport sink(input valid, input channel, input level, input changed, input last,
		output ready);
endinterface

@@ sv/rotating_actuator_crossfade_top.sv @@
// Top level of the rotating actuator crossfade: phase accumulator and two-actuator panning.
//
//  Channel   Direction  Payload                          Handshake
//  tick      in         elapsed_ms[15:0]                 valid / ready
//  result    out        channel, level, changed, last    valid / ready
//  apb       in         paddr[2:0], pwdata[31:0]         psel, penable, pwrite, pready = 1
//
// The time a request takes is set by the single shift-add multiplier, which retires one
// multiplier bit per cycle and is used three times per request: elapsed_ms * frequency,
// that product * 16777, and intensity * fraction.
// Reset clears the phase, the previous levels and both registers to their reset values.
// A stalled result holds in the output register; the next tick is accepted from the cycle
// after the final result of the current one has been loaded into that register.
module rotating_actuator_crossfade_top #(
	parameter int LOG2_OUTPUTS = rac_pkg::LOG2_OUTPUTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rac_tick_if.sink tick,
	rac_result_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rac_pkg::PADDR_W-1:0] paddr,
	input  logic [rac_pkg::PDATA_W-1:0] pwdata,
	output logic [rac_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	localparam int NUM_OUTPUTS = 1 << LOG2_OUTPUTS;
	localparam int FRAC_BITS = rac_pkg::PHASE_W - LOG2_OUTPUTS;
	localparam logic [LOG2_OUTPUTS-1:0] IDX_LAST = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_FREQ,
		ST_MUL_CONST,
		ST_PHASE,
		ST_MUL_LEVEL,
		ST_EMIT
	} state_t;

	// Configuration registers. Write them only while idle; the block does not check.
	logic [rac_pkg::LEVEL_W-1:0] intensity_q;
	logic [rac_pkg::FREQ_W-1:0] freq_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q <= rac_pkg::INTENSITY_RST;
			freq_q <= rac_pkg::FREQ_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				rac_pkg::REG_INTENSITY: intensity_q <= pwdata[rac_pkg::LEVEL_W-1:0];
				rac_pkg::REG_FREQ: freq_q <= pwdata[rac_pkg::FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rac_pkg::REG_INTENSITY: prdata = rac_pkg::PDATA_W'(intensity_q);
			rac_pkg::REG_FREQ: prdata = rac_pkg::PDATA_W'(freq_q);
			default: prdata = '0;
		endcase
	end

	// Shared multiplier.
	rac_pkg::mul_req_t mul_req_q;
	rac_pkg::mul_rsp_t mul_rsp;

	rac_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req_q),
		.rsp(mul_rsp)
	);

	state_t state_q;
	logic [rac_pkg::PHASE_W-1:0] phase_q;
	logic [rac_pkg::LEVEL_W-1:0] up_q;
	logic [rac_pkg::LEVEL_W-1:0] low_q;
	logic [LOG2_OUTPUTS-1:0] idx_q;
	logic [rac_pkg::LEVEL_W-1:0] prev_q [NUM_OUTPUTS];

	logic out_valid_q;
	logic [rac_pkg::CHANNEL_W-1:0] out_channel_q;
	logic [rac_pkg::LEVEL_W-1:0] out_level_q;
	logic out_changed_q;
	logic out_last_q;

	// The top phase bits name the lower actuator; the next one wraps around the ring.
	logic [LOG2_OUTPUTS-1:0] sector;
	logic [LOG2_OUTPUTS-1:0] sector_next;
	logic [rac_pkg::LEVEL_W-1:0] level_cur;
	logic [rac_pkg::LEVEL_W-1:0] up_prod;
	logic rem_nz;
	logic out_free;

	assign sector = phase_q[rac_pkg::PHASE_W-1:FRAC_BITS];
	assign sector_next = sector + LOG2_OUTPUTS'(1);
	assign out_free = !out_valid_q || result.ready;

	// floor(I*f / span) is the upper share. The lower share floor(I*(span-f) / span) equals
	// I minus the ceiling of the same quotient, which is the upper share plus one whenever
	// the low product bits are not all zero.
	assign up_prod = mul_rsp.prod[FRAC_BITS+rac_pkg::LEVEL_W-1:FRAC_BITS];
	assign rem_nz = |mul_rsp.prod[FRAC_BITS-1:0];

	always_comb begin
		if (idx_q == sector) begin
			level_cur = low_q;
		end else if (idx_q == sector_next) begin
			level_cur = up_q;
		end else begin
			level_cur = '0;
		end
	end

	assign tick.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			up_q <= '0;
			low_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				prev_q[i] <= '0;
			end
			mul_req_q <= '0;
			out_valid_q <= 1'b0;
			out_channel_q <= '0;
			out_level_q <= '0;
			out_changed_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			mul_req_q.start <= 1'b0;
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick.valid) begin
						mul_req_q.start <= 1'b1;
						mul_req_q.mcand <= rac_pkg::ACC_W'(freq_q);
						mul_req_q.mplier <= tick.elapsed_ms;
						state_q <= ST_MUL_FREQ;
					end
				end
				ST_MUL_FREQ: begin
					if (mul_rsp.done) begin
						mul_req_q.start <= 1'b1;
						mul_req_q.mcand <= rac_pkg::ACC_W'(mul_rsp.prod[rac_pkg::PHASE_W-1:0]);
						mul_req_q.mplier <= rac_pkg::PHASE_PER_MS_HZ;
						state_q <= ST_MUL_CONST;
					end
				end
				ST_MUL_CONST: begin
					if (mul_rsp.done) begin
						phase_q <= phase_q + mul_rsp.prod[rac_pkg::PHASE_W-1:0];
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					mul_req_q.start <= 1'b1;
					mul_req_q.mcand <= rac_pkg::ACC_W'(phase_q[FRAC_BITS-1:0]);
					mul_req_q.mplier <= rac_pkg::MPLIER_W'(intensity_q);
					state_q <= ST_MUL_LEVEL;
				end
				ST_MUL_LEVEL: begin
					if (mul_rsp.done) begin
						up_q <= up_prod;
						low_q <= intensity_q - up_prod - rac_pkg::LEVEL_W'(rem_nz);
						idx_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_channel_q <= rac_pkg::CHANNEL_W'(idx_q);
						out_level_q <= level_cur;
						out_changed_q <= (level_cur != prev_q[idx_q]);
						out_last_q <= (idx_q == IDX_LAST);
						prev_q[idx_q] <= level_cur;
						idx_q <= idx_q + LOG2_OUTPUTS'(1);
						if (idx_q == IDX_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.channel = out_channel_q;
	assign result.level = out_level_q;
	assign result.changed = out_changed_q;
	assign result.last = out_last_q;

	// The final result of a run always describes the highest actuator.
	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.last) |-> (result.channel == rac_pkg::CHANNEL_W'(IDX_LAST)))
		else $error("last flag on a channel other than the highest");

	// A new multiply request never lands on a multiplier that is still stepping.
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req_q.start |-> !mul_rsp.busy)
		else $error("multiplier restarted while busy");

	// The two shares never add up to more than the peak intensity.
	a_share_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |->
		(({1'b0, low_q} + {1'b0, up_q}) <= {1'b0, intensity_q}))
		else $error("actuator shares exceed intensity");

	// An accepted tick always starts the sequencer.
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> (state_q == ST_MUL_FREQ && mul_req_q.start))
		else $error("accepted tick did not start a multiply");

endmodule

@@ sv/rac_mul.sv @@
// Shift-add multiplier that retires one multiplier bit per cycle.
module rac_mul (
	input  logic clk,
	input  logic arst_n,
	input  rac_pkg::mul_req_t req,
	output rac_pkg::mul_rsp_t rsp
);

	logic [rac_pkg::ACC_W-1:0] acc_q;
	logic [rac_pkg::ACC_W-1:0] mcand_q;
	logic [rac_pkg::MPLIER_W-1:0] mplier_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			mcand_q <= '0;
			mplier_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				acc_q <= '0;
				mcand_q <= req.mcand;
				mplier_q <= req.mplier;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[rac_pkg::ACC_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[rac_pkg::MPLIER_W-1:1]};
				if (mplier_q[rac_pkg::MPLIER_W-1:1] == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	// The product is reported only once the multiplier has been used up.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && mplier_q == '0))
		else $error("multiplier reported done while still stepping");

endmodule
